[design/rpmw_pkg.sv]
// Shared types, constants and codes for the windowed RMS power meter.
// No dependencies; every other design file except rpmw_fifo imports this package.
package rpmw_pkg;

   localparam int ADC_BITS      = 10;
   localparam int COUNT_BITS_DEF = 16;
   localparam int GAIN_BITS     = 28;
   localparam int RMS_BITS      = 18;
   localparam int PWR_BITS      = 47;
   localparam int QUEUE_DEPTH   = 2;

   localparam logic [23:0] K_Q32  = 24'd13841176;
   localparam logic [63:0] K2_FULL = (64'(K_Q32) * 64'(K_Q32)) >> 16;
   localparam logic [31:0] K2_Q48 = K2_FULL[31:0];
   localparam logic [RMS_BITS-1:0] RMS_MAX = '1;
   localparam logic [PWR_BITS-1:0] PWR_MAX = '1;

   typedef enum logic [1:0] {
      CSR_CURRENT_OFFSET = 2'd0,
      CSR_VOLTAGE_OFFSET = 2'd1,
      CSR_VOLTAGE_GAIN   = 2'd2,
      CSR_CURRENT_GAIN   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [ADC_BITS-1:0] current_sample;
      logic [ADC_BITS-1:0] voltage_sample;
      logic                window_end;
   } req_type;

   typedef struct packed {
      logic [RMS_BITS-1:0]      rms_current;
      logic [RMS_BITS-1:0]      rms_voltage;
      logic signed [47:0]       real_power;
      logic [PWR_BITS-1:0]      apparent_power;
      logic signed [15:0]       power_factor;
      logic [15:0]              sample_count;
   } rsp_type;

   typedef enum logic [1:0] {
      ALU_MUL,
      ALU_DIV,
      ALU_SQRT
   } alu_op_type;

   typedef enum logic {
      ALU_IDLE,
      ALU_RUN
   } alu_state_type;

   typedef struct packed {
      logic       start;
      alu_op_type op;
   } alu_cmd_type;

   typedef struct packed {
      logic done;
   } alu_stat_type;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_GAIN,
      BK_DIV_I,
      BK_SQRT_I,
      BK_RMS_I,
      BK_DIV_V,
      BK_SQRT_V,
      BK_RMS_V,
      BK_MEAN_P,
      BK_SCALE_P,
      BK_REAL,
      BK_VI,
      BK_APP,
      BK_PF,
      BK_OUT
   } bk_state_type;

endpackage

[design/rpmw_fifo.sv]
// Small register queue with push/full and pop/empty sides.
// Depends on nothing but its parameters.
module rpmw_fifo #(
   parameter int DATA_BITS = 8,
   parameter int DEPTH     = 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  logic [DATA_BITS-1:0] din,
   output logic                 full,
   input  logic                 pop,
   output logic [DATA_BITS-1:0] dout,
   output logic                 empty
);
   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [DATA_BITS-1:0] mem_ff [DEPTH];
   logic [PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic                 do_push, do_pop;

   assign full    = (count_ff == CNT_BITS'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign dout    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= din;
      end
   end
endmodule

[design/rpmw_front.sv]
// Front end: removes offsets, accumulates squares, products and pair count,
// and closes a window into the queue. Uses rpmw_pkg.
module rpmw_front #(
   parameter int COUNT_BITS = rpmw_pkg::COUNT_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               accept,
   input  rpmw_pkg::req_type                  req,
   input  logic [rpmw_pkg::ADC_BITS-1:0]      current_offset,
   input  logic [rpmw_pkg::ADC_BITS-1:0]      voltage_offset,
   output logic                               win_push,
   output logic [2*rpmw_pkg::ADC_BITS+COUNT_BITS-1:0] win_sq_i,
   output logic [2*rpmw_pkg::ADC_BITS+COUNT_BITS-1:0] win_sq_v,
   output logic signed [2*rpmw_pkg::ADC_BITS+COUNT_BITS:0] win_prod,
   output logic [COUNT_BITS-1:0]              win_count
);
   import rpmw_pkg::*;

   localparam int SW = 2 * ADC_BITS + COUNT_BITS;
   localparam int PW = SW + 1;
   localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

   logic signed [ADC_BITS:0]     di, dv;
   logic signed [2*ADC_BITS+1:0] sqi, sqv, prod;
   logic [SW-1:0]                sum_i_ff, sum_i_in, sum_v_ff, sum_v_in;
   logic [SW-1:0]                acc_i, acc_v;
   logic signed [PW-1:0]         sum_p_ff, sum_p_in, acc_p;
   logic [COUNT_BITS-1:0]        cnt_ff, cnt_in, cnt_next;
   logic                         close;

   always_comb begin
      di       = $signed({1'b0, req.current_sample}) - $signed({1'b0, current_offset});
      dv       = $signed({1'b0, req.voltage_sample}) - $signed({1'b0, voltage_offset});
      sqi      = di * di;
      sqv      = dv * dv;
      prod     = di * dv;
      acc_i    = sum_i_ff + SW'(sqi[2*ADC_BITS-1:0]);
      acc_v    = sum_v_ff + SW'(sqv[2*ADC_BITS-1:0]);
      acc_p    = sum_p_ff + PW'(prod);
      cnt_next = cnt_ff + 1'b1;
      close    = req.window_end | (cnt_next == CNT_MAX);

      win_push  = accept & close;
      win_sq_i  = acc_i;
      win_sq_v  = acc_v;
      win_prod  = acc_p;
      win_count = cnt_next;

      sum_i_in = sum_i_ff;
      sum_v_in = sum_v_ff;
      sum_p_in = sum_p_ff;
      cnt_in   = cnt_ff;
      if (accept) begin
         if (close) begin
            sum_i_in = '0;
            sum_v_in = '0;
            sum_p_in = '0;
            cnt_in   = '0;
         end else begin
            sum_i_in = acc_i;
            sum_v_in = acc_v;
            sum_p_in = acc_p;
            cnt_in   = cnt_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_i_ff <= '0;
         sum_v_ff <= '0;
         sum_p_ff <= '0;
         cnt_ff   <= '0;
      end else begin
         sum_i_ff <= sum_i_in;
         sum_v_ff <= sum_v_in;
         sum_p_ff <= sum_p_in;
         cnt_ff   <= cnt_in;
      end
   end
endmodule

[design/rpmw_alu.sv]
// Shared bit-serial unit: shift-add multiply, restoring divide, square root.
// Uses rpmw_pkg for its command and status types.
module rpmw_alu #(
   parameter int WW = 108
) (
   input  logic                  clock,
   input  logic                  reset,
   input  rpmw_pkg::alu_cmd_type cmd,
   input  logic [WW-1:0]         opa,
   input  logic [WW-1:0]         opb,
   output rpmw_pkg::alu_stat_type stat,
   output logic [WW-1:0]         result
);
   import rpmw_pkg::*;

   localparam int CW = $clog2(WW + 1);

   alu_state_type   state_ff, state_in;
   alu_op_type      op_ff, op_in;
   logic [WW-1:0]   a_ff, a_in, b_ff, b_in, acc_ff, acc_in;
   logic [WW+1:0]   rem_ff, rem_in, rem_sh, trial;
   logic [CW-1:0]   cnt_ff, cnt_in;

   assign result = acc_ff;

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      acc_in    = acc_ff;
      rem_in    = rem_ff;
      cnt_in    = cnt_ff;
      rem_sh    = '0;
      trial     = '0;
      stat.done = 1'b0;
      case (state_ff)
         ALU_IDLE: begin
            if (cmd.start) begin
               a_in     = opa;
               b_in     = opb;
               acc_in   = '0;
               rem_in   = '0;
               op_in    = cmd.op;
               cnt_in   = (cmd.op == ALU_SQRT) ? CW'(WW / 2) : CW'(WW);
               state_in = ALU_RUN;
            end
         end
         ALU_RUN: begin
            case (op_ff)
               ALU_MUL: begin
                  if (b_ff == '0) begin
                     stat.done = 1'b1;
                     state_in  = ALU_IDLE;
                  end else begin
                     if (b_ff[0]) begin
                        acc_in = acc_ff + a_ff;
                     end
                     a_in = a_ff << 1;
                     b_in = b_ff >> 1;
                  end
               end
               ALU_DIV: begin
                  if (cnt_ff == '0) begin
                     stat.done = 1'b1;
                     state_in  = ALU_IDLE;
                  end else begin
                     rem_sh = {rem_ff[WW:0], a_ff[WW-1]};
                     trial  = {2'b00, b_ff};
                     if (rem_sh >= trial) begin
                        rem_in = rem_sh - trial;
                        acc_in = {acc_ff[WW-2:0], 1'b1};
                     end else begin
                        rem_in = rem_sh;
                        acc_in = {acc_ff[WW-2:0], 1'b0};
                     end
                     a_in   = a_ff << 1;
                     cnt_in = cnt_ff - 1'b1;
                  end
               end
               ALU_SQRT: begin
                  if (cnt_ff == '0) begin
                     stat.done = 1'b1;
                     state_in  = ALU_IDLE;
                  end else begin
                     rem_sh = {rem_ff[WW-1:0], a_ff[WW-1:WW-2]};
                     trial  = {acc_ff, 2'b01};
                     if (rem_sh >= trial) begin
                        rem_in = rem_sh - trial;
                        acc_in = {acc_ff[WW-2:0], 1'b1};
                     end else begin
                        rem_in = rem_sh;
                        acc_in = {acc_ff[WW-2:0], 1'b0};
                     end
                     a_in   = a_ff << 2;
                     cnt_in = cnt_ff - 1'b1;
                  end
               end
               default: begin
                  state_in = ALU_IDLE;
               end
            endcase
         end
         default: begin
            state_in = ALU_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ALU_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
   end
endmodule

[design/rpmw_back.sv]
// Back end: sequences the shared arithmetic unit over one closed window and
// forms the result transaction. Uses rpmw_pkg and rpmw_alu.
module rpmw_back #(
   parameter int COUNT_BITS = rpmw_pkg::COUNT_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 win_empty,
   output logic                                 win_pop,
   input  logic [2*rpmw_pkg::ADC_BITS+COUNT_BITS-1:0] win_sq_i,
   input  logic [2*rpmw_pkg::ADC_BITS+COUNT_BITS-1:0] win_sq_v,
   input  logic signed [2*rpmw_pkg::ADC_BITS+COUNT_BITS:0] win_prod,
   input  logic [COUNT_BITS-1:0]                win_count,
   input  logic [rpmw_pkg::GAIN_BITS-1:0]       voltage_gain,
   input  logic [rpmw_pkg::GAIN_BITS-1:0]       current_gain,
   input  logic                                 out_full,
   output logic                                 out_push,
   output rpmw_pkg::rsp_type                    out_data
);
   import rpmw_pkg::*;

   localparam int SW = 2 * ADC_BITS + COUNT_BITS;
   localparam int PW = SW + 1;
   localparam int WW = 2 * ((2 * ADC_BITS + COUNT_BITS + 73) / 2);
   localparam int RW = ADC_BITS + 8;
   localparam int GW = 2 * GAIN_BITS;

   bk_state_type          state_ff, state_in;
   logic                  issued_ff, issued_in;
   logic [SW-1:0]         si_ff, si_in, sv_ff, sv_in, mag_ff, mag_in;
   logic [PW-1:0]         neg_prod;
   logic                  neg_ff, neg_in;
   logic [COUNT_BITS-1:0] n_ff, n_in;
   logic [GW-1:0]         g_ff, g_in;
   logic [WW-1:0]         tmp_ff, tmp_in;
   logic [RW-1:0]         irms_ff, irms_in, vrms_ff, vrms_in;
   logic [PWR_BITS-1:0]   p_ff, p_in, s_ff, s_in;
   logic                  is_op;
   alu_cmd_type           cmd;
   alu_stat_type          stat;
   logic [WW-1:0]         opa, opb, res;
   logic [16:0]           pf_mag;

   function automatic logic [PWR_BITS-1:0] sat_pwr(input logic [WW-1:0] v);
      logic [WW-1:0] lim;
      lim = WW'(PWR_MAX);
      sat_pwr = (v > lim) ? PWR_MAX : v[PWR_BITS-1:0];
   endfunction

   rpmw_alu #(.WW(WW)) u_alu (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .opa    (opa),
      .opb    (opb),
      .stat   (stat),
      .result (res)
   );

   assign neg_prod = -win_prod;

   always_comb begin
      state_in  = state_ff;
      issued_in = issued_ff;
      si_in     = si_ff;
      sv_in     = sv_ff;
      mag_in    = mag_ff;
      neg_in    = neg_ff;
      n_in      = n_ff;
      g_in      = g_ff;
      tmp_in    = tmp_ff;
      irms_in   = irms_ff;
      vrms_in   = vrms_ff;
      p_in      = p_ff;
      s_in      = s_ff;
      is_op     = 1'b1;
      cmd.start = 1'b0;
      cmd.op    = ALU_MUL;
      opa       = '0;
      opb       = '0;
      win_pop   = 1'b0;
      out_push  = 1'b0;

      case (state_ff)
         BK_IDLE: begin
            is_op = 1'b0;
            if (!win_empty) begin
               win_pop  = 1'b1;
               si_in    = win_sq_i;
               sv_in    = win_sq_v;
               neg_in   = win_prod[PW-1];
               mag_in   = win_prod[PW-1] ? neg_prod[SW-1:0] : win_prod[SW-1:0];
               n_in     = win_count;
               state_in = BK_GAIN;
            end
         end
         BK_GAIN: begin
            opa = WW'(voltage_gain);
            opb = WW'(current_gain);
         end
         BK_DIV_I: begin
            cmd.op = ALU_DIV;
            opa    = WW'({si_ff, 32'd0});
            opb    = WW'(n_ff);
         end
         BK_SQRT_I, BK_SQRT_V: begin
            cmd.op = ALU_SQRT;
            opa    = tmp_ff;
         end
         BK_RMS_I, BK_RMS_V: begin
            opa = tmp_ff;
            opb = WW'(K_Q32);
         end
         BK_DIV_V: begin
            cmd.op = ALU_DIV;
            opa    = WW'({sv_ff, 32'd0});
            opb    = WW'(n_ff);
         end
         BK_MEAN_P: begin
            cmd.op = ALU_DIV;
            opa    = WW'({mag_ff, 16'd0});
            opb    = WW'(n_ff);
         end
         BK_SCALE_P: begin
            opa = tmp_ff;
            opb = WW'(K2_Q48);
         end
         BK_REAL, BK_APP: begin
            opa = tmp_ff;
            opb = WW'(g_ff);
         end
         BK_VI: begin
            opa = WW'(irms_ff);
            opb = WW'(vrms_ff);
         end
         BK_PF: begin
            cmd.op = ALU_DIV;
            opa    = WW'({p_ff, 15'd0});
            opb    = WW'(s_ff);
            if (s_ff == '0) begin
               is_op    = 1'b0;
               state_in = BK_OUT;
            end
         end
         BK_OUT: begin
            is_op = 1'b0;
            if (!out_full) begin
               out_push = 1'b1;
               state_in = BK_IDLE;
            end
         end
         default: begin
            is_op    = 1'b0;
            state_in = BK_IDLE;
         end
      endcase

      if (is_op && !issued_ff) begin
         cmd.start = 1'b1;
         issued_in = 1'b1;
      end

      if (is_op && issued_ff && stat.done) begin
         issued_in = 1'b0;
         case (state_ff)
            BK_GAIN: begin
               g_in     = res[GW-1:0];
               state_in = BK_DIV_I;
            end
            BK_DIV_I: begin
               tmp_in   = res;
               state_in = BK_SQRT_I;
            end
            BK_SQRT_I: begin
               tmp_in   = res;
               state_in = BK_RMS_I;
            end
            BK_RMS_I: begin
               irms_in  = RW'(res >> 32);
               state_in = BK_DIV_V;
            end
            BK_DIV_V: begin
               tmp_in   = res;
               state_in = BK_SQRT_V;
            end
            BK_SQRT_V: begin
               tmp_in   = res;
               state_in = BK_RMS_V;
            end
            BK_RMS_V: begin
               vrms_in  = RW'(res >> 32);
               state_in = BK_MEAN_P;
            end
            BK_MEAN_P: begin
               tmp_in   = res;
               state_in = BK_SCALE_P;
            end
            BK_SCALE_P: begin
               tmp_in   = res >> 48;
               state_in = BK_REAL;
            end
            BK_REAL: begin
               p_in     = sat_pwr(res >> 32);
               state_in = BK_VI;
            end
            BK_VI: begin
               tmp_in   = res;
               state_in = BK_APP;
            end
            BK_APP: begin
               s_in     = sat_pwr(res >> 48);
               state_in = BK_PF;
            end
            BK_PF: begin
               tmp_in   = res;
               state_in = BK_OUT;
            end
            default: begin
               state_in = BK_IDLE;
            end
         endcase
      end
   end

   always_comb begin
      out_data.rms_current = (irms_ff > RW'(RMS_MAX)) ? RMS_MAX : RMS_BITS'(irms_ff);
      out_data.rms_voltage = (vrms_ff > RW'(RMS_MAX)) ? RMS_MAX : RMS_BITS'(vrms_ff);
      out_data.real_power  = neg_ff ? -$signed({1'b0, p_ff}) : $signed({1'b0, p_ff});
      out_data.sample_count = (32'(n_ff) > 32'd65535) ? 16'hFFFF : 16'(n_ff);
      pf_mag = '0;
      if (s_ff == '0) begin
         out_data.apparent_power = PWR_BITS'(65536);
         out_data.power_factor   = 16'sd32767;
      end else begin
         out_data.apparent_power = s_ff;
         if (neg_ff) begin
            pf_mag = (tmp_ff > WW'(32768)) ? 17'd32768 : tmp_ff[16:0];
            out_data.power_factor = -$signed(pf_mag[15:0]);
         end else begin
            pf_mag = (tmp_ff > WW'(32767)) ? 17'd32767 : tmp_ff[16:0];
            out_data.power_factor = $signed(pf_mag[15:0]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= BK_IDLE;
         issued_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         issued_ff <= issued_in;
      end
   end

   always_ff @(posedge clock) begin
      si_ff   <= si_in;
      sv_ff   <= sv_in;
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      n_ff    <= n_in;
      g_ff    <= g_in;
      tmp_ff  <= tmp_in;
      irms_ff <= irms_in;
      vrms_ff <= vrms_in;
      p_ff    <= p_in;
      s_ff    <= s_in;
   end
endmodule

[design/rms_power_meter_window.sv]
// Single-phase RMS and power meter. A sample pair is taken on every cycle that
// push is high and full is low, and the front end adds each taken pair to its
// registered sums, so input throughput is one pair per clock while full stays
// low. On window end (or when the pair count saturates) the window's sums enter
// a two-entry queue and a back end works them through one shared bit-serial
// multiply/divide/square-root unit before the result joins a two-entry result
// queue. full rises only while two closed windows wait for that unit.
// Uses rpmw_pkg, rpmw_fifo, rpmw_front and rpmw_back.
module rms_power_meter_window #(
   parameter int COUNT_BITS = rpmw_pkg::COUNT_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   output logic                              full,
   input  rpmw_pkg::req_type                 req_payload,
   output logic                              empty,
   input  logic                              pop,
   output rpmw_pkg::rsp_type                 rsp_payload,
   input  logic                              csr_we,
   input  rpmw_pkg::csr_index_type           csr_index,
   input  logic [rpmw_pkg::GAIN_BITS-1:0]    csr_wdata
);
   import rpmw_pkg::*;

   localparam int SW = 2 * ADC_BITS + COUNT_BITS;
   localparam int PW = SW + 1;
   localparam int MW = 2 * SW + PW + COUNT_BITS;
   localparam int RB = $bits(rsp_type);

   logic [ADC_BITS-1:0]   cur_off_ff, volt_off_ff;
   logic [GAIN_BITS-1:0]  volt_gain_ff, cur_gain_ff;
   logic                  accept;
   logic                  win_push, win_pop, win_empty, out_full, out_push;
   logic [SW-1:0]         f_sq_i, f_sq_v, b_sq_i, b_sq_v;
   logic signed [PW-1:0]  f_prod, b_prod;
   logic [COUNT_BITS-1:0] f_count, b_count;
   logic [MW-1:0]         win_din, win_dout;
   rsp_type               out_data;
   logic [RB-1:0]         rsp_bits;

   assign accept  = push & ~full;
   assign win_din = {f_sq_i, f_sq_v, f_prod, f_count};
   assign {b_sq_i, b_sq_v, b_prod, b_count} = win_dout;
   assign rsp_payload = rsp_type'(rsp_bits);

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_off_ff   <= ADC_BITS'(512);
         volt_off_ff  <= ADC_BITS'(512);
         volt_gain_ff <= GAIN_BITS'(65536);
         cur_gain_ff  <= GAIN_BITS'(65536);
      end else if (csr_we) begin
         case (csr_index)
            CSR_CURRENT_OFFSET: cur_off_ff   <= csr_wdata[ADC_BITS-1:0];
            CSR_VOLTAGE_OFFSET: volt_off_ff  <= csr_wdata[ADC_BITS-1:0];
            CSR_VOLTAGE_GAIN:   volt_gain_ff <= csr_wdata;
            CSR_CURRENT_GAIN:   cur_gain_ff  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   rpmw_front #(.COUNT_BITS(COUNT_BITS)) u_front (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .req            (req_payload),
      .current_offset (cur_off_ff),
      .voltage_offset (volt_off_ff),
      .win_push       (win_push),
      .win_sq_i       (f_sq_i),
      .win_sq_v       (f_sq_v),
      .win_prod       (f_prod),
      .win_count      (f_count)
   );

   rpmw_fifo #(.DATA_BITS(MW), .DEPTH(QUEUE_DEPTH)) u_win_queue (
      .clock (clock),
      .reset (reset),
      .push  (win_push),
      .din   (win_din),
      .full  (full),
      .pop   (win_pop),
      .dout  (win_dout),
      .empty (win_empty)
   );

   rpmw_back #(.COUNT_BITS(COUNT_BITS)) u_back (
      .clock        (clock),
      .reset        (reset),
      .win_empty    (win_empty),
      .win_pop      (win_pop),
      .win_sq_i     (b_sq_i),
      .win_sq_v     (b_sq_v),
      .win_prod     (b_prod),
      .win_count    (b_count),
      .voltage_gain (volt_gain_ff),
      .current_gain (cur_gain_ff),
      .out_full     (out_full),
      .out_push     (out_push),
      .out_data     (out_data)
   );

   rpmw_fifo #(.DATA_BITS(RB), .DEPTH(QUEUE_DEPTH)) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .din   (RB'(out_data)),
      .full  (out_full),
      .pop   (pop),
      .dout  (rsp_bits),
      .empty (empty)
   );
endmodule

[tb/rms_power_meter_window_tb.sv]
// Testbench for rms_power_meter_window: directed rows then random sample windows,
// with a built-in RMS/power calculator checking every result transaction.
// Depends on rpmw_pkg and the rms_power_meter_window RTL only.
`timescale 1ns / 1ps

module rms_power_meter_window_tb;
   import rpmw_pkg::*;

   localparam longint unsigned VOLT_K  = 64'd13841176;
   localparam longint unsigned VOLT_K2 = (64'd13841176 * 64'd13841176) >> 16;
   localparam longint unsigned PWR_TOP = (64'd1 << 47) - 1;
   localparam longint unsigned CNT_TOP = 64'd65535;
   localparam longint unsigned RMS_TOP = 64'd262143;

   typedef struct {
      logic [9:0] cur;
      logic [9:0] volt;
      logic       last;
      bit         fixed;
      rsp_type    known;
   } dir_row_type;

   logic          clock = 0;
   logic          reset = 1;
   logic          push = 0;
   logic          full;
   req_type       req_payload = '0;
   logic          empty;
   logic          pop = 0;
   rsp_type       rsp_payload;
   logic          csr_we = 0;
   csr_index_type csr_index = CSR_CURRENT_OFFSET;
   logic [GAIN_BITS-1:0] csr_wdata = '0;

   rsp_type          pending_results[$];
   int               mismatches = 0;
   int               results_seen = 0;
   int               items_sent = 0;
   int               pop_hold = 0;

   longint unsigned  cal_cur_off, cal_volt_off, cal_volt_gain, cal_cur_gain;
   longint unsigned  acc_sq_cur, acc_sq_volt, acc_pairs;
   longint           acc_prod;

   rms_power_meter_window uut (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .req_payload(req_payload), .empty(empty), .pop(pop),
      .rsp_payload(rsp_payload), .csr_we(csr_we), .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   initial begin
      #50_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   function automatic longint unsigned mul_shift(longint unsigned a, longint unsigned b,
                                                 int sh);
      logic [127:0] pr;
      pr = (128'(a) * 128'(b)) >> sh;
      if (pr[127:64] != 0) return '1;
      return pr[63:0];
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic longint unsigned frac_mean(longint unsigned sum, longint unsigned n,
                                                 int fb);
      return ((sum / n) << fb) + ((sum % n) << fb) / n;
   endfunction

   function automatic longint unsigned pin_rms(longint unsigned sum, longint unsigned n);
      return mul_shift(int_sqrt(frac_mean(sum, n, 32)), VOLT_K, 32);
   endfunction

   // accumulate one sample pair; close the window on its end or a full count
   task automatic meter_accumulate(req_type r);
      longint          di, dv;
      longint unsigned n, irms, vrms, g, mag, p, s, m, pf;
      bit              neg;
      rsp_type         res;
      di = longint'(r.current_sample) - longint'(cal_cur_off);
      dv = longint'(r.voltage_sample) - longint'(cal_volt_off);
      acc_sq_cur  += di * di;
      acc_sq_volt += dv * dv;
      acc_prod    += di * dv;
      acc_pairs++;
      if (!r.window_end && acc_pairs < CNT_TOP) return;
      n    = acc_pairs;
      irms = pin_rms(acc_sq_cur, n);
      vrms = pin_rms(acc_sq_volt, n);
      g    = cal_volt_gain * cal_cur_gain;
      neg  = acc_prod < 0;
      mag  = neg ? -acc_prod : acc_prod;
      p = mul_shift(mul_shift(frac_mean(mag, n, 16), VOLT_K2, 48), g, 32);
      if (p > PWR_TOP) p = PWR_TOP;
      s = mul_shift(mul_shift(irms, vrms, 0), g, 48);
      if (s > PWR_TOP) s = PWR_TOP;
      if (s == 0) begin
         s  = 65536;
         pf = 32767;
      end else begin
         m = (p << 15) / s;
         if (neg) begin
            if (m > 32768) m = 32768;
            pf = (-m) & 64'hFFFF;
         end else begin
            pf = (m > 32767) ? 32767 : m;
         end
      end
      res.rms_current    = RMS_BITS'((irms > RMS_TOP) ? RMS_TOP : irms);
      res.rms_voltage    = RMS_BITS'((vrms > RMS_TOP) ? RMS_TOP : vrms);
      res.real_power     = 48'(neg ? -p : p);
      res.apparent_power = PWR_BITS'(s);
      res.power_factor   = 16'(pf);
      res.sample_count   = 16'((n > CNT_TOP) ? CNT_TOP : n);
      pending_results.push_back(res);
      acc_sq_cur  = 0;
      acc_sq_volt = 0;
      acc_prod    = 0;
      acc_pairs   = 0;
   endtask

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(99);
      if (roll < 65) return 0;
      if (roll < 95) return $urandom_range(3, 1);
      return $urandom_range(80, 20);
   endfunction

   task automatic send_sample(req_type r, int gap);
      push        <= 1;
      req_payload <= r;
      do @(posedge clock); while (full);
      items_sent++;
      if (gap > 0) begin
         push <= 0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic csr_write(csr_index_type idx, longint unsigned value);
      csr_we    <= 1;
      csr_index <= idx;
      csr_wdata <= GAIN_BITS'(value);
      @(posedge clock);
      csr_we    <= 0;
      case (idx)
         CSR_CURRENT_OFFSET: cal_cur_off   = value & 64'h3FF;
         CSR_VOLTAGE_OFFSET: cal_volt_off  = value & 64'h3FF;
         CSR_VOLTAGE_GAIN:   cal_volt_gain = value & 64'hFFF_FFFF;
         CSR_CURRENT_GAIN:   cal_cur_gain  = value & 64'hFFF_FFFF;
         default: begin
         end
      endcase
   endtask

   // drain results, then let the back end settle before touching the registers
   task automatic wait_idle();
      push <= 0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (1000) @(posedge clock);
   endtask

   task automatic setup_meter(longint unsigned co, longint unsigned vo,
                              longint unsigned vg, longint unsigned cg);
      wait_idle();
      csr_write(CSR_CURRENT_OFFSET, co);
      csr_write(CSR_VOLTAGE_OFFSET, vo);
      csr_write(CSR_VOLTAGE_GAIN, vg);
      csr_write(CSR_CURRENT_GAIN, cg);
   endtask

   task automatic report_mismatch(string field, longint got, longint want);
      $display("mismatch on %s: got %0d, want %0d (result %0d)", field, got, want,
               results_seen);
      mismatches++;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && pop && !empty) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected transaction", 1, 0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_payload.rms_current != want.rms_current)
               report_mismatch("rms_current", longint'(rsp_payload.rms_current),
                               longint'(want.rms_current));
            if (rsp_payload.rms_voltage != want.rms_voltage)
               report_mismatch("rms_voltage", longint'(rsp_payload.rms_voltage),
                               longint'(want.rms_voltage));
            if (rsp_payload.real_power != want.real_power)
               report_mismatch("real_power", longint'(rsp_payload.real_power),
                               longint'(want.real_power));
            if (rsp_payload.apparent_power != want.apparent_power)
               report_mismatch("apparent_power", longint'(rsp_payload.apparent_power),
                               longint'(want.apparent_power));
            if (rsp_payload.power_factor != want.power_factor)
               report_mismatch("power_factor", longint'(rsp_payload.power_factor),
                               longint'(want.power_factor));
            if (rsp_payload.sample_count != want.sample_count)
               report_mismatch("sample_count", longint'(rsp_payload.sample_count),
                               longint'(want.sample_count));
         end
      end
      if (pop_hold > 0) begin
         pop <= 0;
         pop_hold <= pop_hold - 1;
      end else if ($urandom_range(99) < 25) begin
         pop <= 0;
         pop_hold <= pick_gap();
      end else begin
         pop <= 1;
      end
   end

   initial begin
      dir_row_type     dir_rows[$];
      dir_row_type     row;
      rsp_type         idle_res;
      req_type         r;
      int              phase, left, wlen, sent;
      longint unsigned co, vo, vg, cg;

      idle_res = '{rms_current: 18'd0, rms_voltage: 18'd0, real_power: 48'sd0,
                   apparent_power: 47'd65536, power_factor: 16'sd32767,
                   sample_count: 16'd1};
      cal_cur_off = 512; cal_volt_off = 512; cal_volt_gain = 65536; cal_cur_gain = 65536;
      acc_sq_cur = 0; acc_sq_volt = 0; acc_prod = 0; acc_pairs = 0;

      dir_rows = '{
         '{10'd512,  10'd512,  1'b1, 1'b1, idle_res},
         '{10'd1023, 10'd1023, 1'b1, 1'b0, '0},
         '{10'd0,    10'd0,    1'b1, 1'b0, '0},
         '{10'd1023, 10'd0,    1'b1, 1'b0, '0},
         '{10'd0,    10'd1023, 1'b0, 1'b0, '0},
         '{10'd1023, 10'd1023, 1'b1, 1'b0, '0},
         '{10'd700,  10'd300,  1'b0, 1'b0, '0},
         '{10'd512,  10'd900,  1'b0, 1'b0, '0},
         '{10'd100,  10'd600,  1'b1, 1'b0, '0},
         '{10'd341,  10'd682,  1'b0, 1'b0, '0},
         '{10'd682,  10'd341,  1'b1, 1'b0, '0},
         '{10'd512,  10'd1023, 1'b1, 1'b0, '0}
      };

      repeat (2) @(posedge clock);
      reset <= 0;

      foreach (dir_rows[i]) begin
         row = dir_rows[i];
         r = '{current_sample: row.cur, voltage_sample: row.volt, window_end: row.last};
         meter_accumulate(r);
         if (row.fixed) begin
            void'(pending_results.pop_back());
            pending_results.push_back(row.known);
         end
         send_sample(r, pick_gap());
      end

      for (phase = 0; phase < 7; phase++) begin
         case (phase)
            0: begin co = 0;    vo = 0;    vg = 268435455; cg = 268435455; end
            1: begin co = 1023; vo = 1023; vg = 0;         cg = 0;         end
            2: begin co = 512;  vo = 512;  vg = 65536;     cg = 65536;     end
            default: begin
               co = 64'($urandom_range(1023));
               vo = 64'($urandom_range(1023));
               vg = ($urandom_range(3) == 0) ? 64'($urandom_range(268435455))
                                            : 64'($urandom_range(1 << 20));
               cg = ($urandom_range(3) == 0) ? 64'($urandom_range(268435455))
                                            : 64'($urandom_range(1 << 20));
            end
         endcase
         setup_meter(co, vo, vg, cg);
         sent = 0;
         while (sent < 200) begin
            wlen = ($urandom_range(9) == 0) ? $urandom_range(120, 20) : $urandom_range(12, 1);
            for (left = wlen; left > 0; left--) begin
               r.current_sample = ADC_BITS'($urandom_range(1023));
               r.voltage_sample = ADC_BITS'($urandom_range(1023));
               r.window_end     = (left == 1);
               meter_accumulate(r);
               send_sample(r, pick_gap());
               sent++;
            end
         end
      end

      wait_idle();
      $display("Covered %0d sample pairs and %0d result transactions over 8 settings,",
               items_sent, results_seen);
      $display("with windows from a single pair up to more than a hundred pairs.");
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
